// ===== src/solenoid_valve_pulse_relief_controller_core_assert.svh =====
// Assertion macros for the solenoid valve controller checker.
// Needs nothing else; included by the checker file only.
`ifndef SOLENOID_VALVE_PULSE_RELIEF_CONTROLLER_CORE_ASSERT_SVH
`define SOLENOID_VALVE_PULSE_RELIEF_CONTROLLER_CORE_ASSERT_SVH

// Clocked assertion, off while reset is held.
`define SVPRC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("svprc assertion failed");

// Same, for properties that must hold even during reset.
`define SVPRC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("svprc assertion failed");

`endif

// ===== src/svprc_pkg.sv =====
// Types, register indexes and codes for the solenoid valve controller.
// No dependencies.
package svprc_pkg;

    localparam int unsigned TIME_W   = 16;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_NORMALLY_OPEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_VALVE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TIME     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POWER_TIME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELIEF_TIME    = 3'd4;

    localparam logic [TIME_W-1:0] PULSE_TIME_RST     = 16'd1000;
    localparam logic [TIME_W-1:0] MAX_POWER_TIME_RST = 16'd1000;
    localparam logic [TIME_W-1:0] RELIEF_TIME_RST    = 16'd100;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_CLOSE = 3'd1;
    localparam logic [2:0] ACT_OPEN  = 3'd2;
    localparam logic [2:0] ACT_PULSE = 3'd3;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_CLOSE = 2'd1;
    localparam logic [1:0] MODE_OPEN  = 2'd2;
    localparam logic [1:0] MODE_PULSE = 2'd3;

    localparam logic CMD_TICK = 1'b0;

    typedef struct packed {
        logic       command;
        logic [2:0] action;
    } t_in;

    typedef struct packed {
        logic       drive_level;
        logic       valve_open;
        logic [1:0] mode;
        logic       relieving;
        logic       error_flag;
    } t_out;

endpackage

// ===== src/solenoid_valve_pulse_relief_controller_core.sv =====
// Solenoid valve controller: pulse timing and hold relief, one beat per cycle unless the output stalls.
// Depends on svprc_pkg.
//
// Usage:
//  - Input channel (i_valid/o_ready/i_data): each beat is a 1 ms tick
//    (command 0) or an actuation request (command 1, action code).
//  - Output channel (o_valid/i_ready/o_data): one result beat per input
//    beat, in order, giving the valve state after that input.
//  - Config port (i_cfg_we/i_cfg_idx/i_cfg_data): single-cycle writes,
//    indexes 0..4; write only while no beat is in flight.
//  - Path: the beat lands in the input register, and the updated state is
//    loaded into the result register once the result register can advance.
//  - Throughput: 1 beat per cycle while the output is not stalled; the state
//    update is one short pass of logic (increment plus three 16-bit compares).
//  - Reset: clears both pipeline stages, the valve state and the error
//    flag, and restores the config defaults.
//  - Output stall: the result register holds; one more beat is taken into
//    the input register, then o_ready drops until the result is taken.
module solenoid_valve_pulse_relief_controller_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  svprc_pkg::t_in                      i_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output svprc_pkg::t_out                     o_data,
    input  logic                                i_cfg_we,
    input  logic [svprc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [svprc_pkg::TIME_W-1:0]        i_cfg_data
);

    localparam logic [svprc_pkg::TIME_W-1:0] TIME_MAX = '1;
    localparam logic [svprc_pkg::TIME_W-1:0] TIME_ONE = {{(svprc_pkg::TIME_W-1){1'b0}}, 1'b1};

    // config
    logic                        r_normally_open;
    logic                        r_special_valve;
    logic [svprc_pkg::TIME_W-1:0] r_pulse_time;
    logic [svprc_pkg::TIME_W-1:0] r_max_power_time;
    logic [svprc_pkg::TIME_W-1:0] r_relief_time;

    // valve state
    logic                        r_drive, n_drive;
    logic [svprc_pkg::TIME_W-1:0] r_elapsed, n_elapsed;
    logic                        r_relief, n_relief;
    logic [1:0]                  r_mode, n_mode;
    logic                        r_error, n_error;

    // pipeline
    logic            r_in_valid;
    svprc_pkg::t_in  r_in;
    logic            r_out_valid;
    svprc_pkg::t_out r_out;

    logic advance;
    logic open_lvl;
    logic close_lvl;

    assign advance   = !r_out_valid || i_ready;
    assign o_ready   = !r_in_valid || advance;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;
    assign open_lvl  = !r_normally_open;
    assign close_lvl = r_normally_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normally_open  <= 1'b0;
            r_special_valve  <= 1'b0;
            r_pulse_time     <= svprc_pkg::PULSE_TIME_RST;
            r_max_power_time <= svprc_pkg::MAX_POWER_TIME_RST;
            r_relief_time    <= svprc_pkg::RELIEF_TIME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                svprc_pkg::CFG_NORMALLY_OPEN:  r_normally_open  <= i_cfg_data[0];
                svprc_pkg::CFG_SPECIAL_VALVE:  r_special_valve  <= i_cfg_data[0];
                svprc_pkg::CFG_PULSE_TIME:     r_pulse_time     <= i_cfg_data;
                svprc_pkg::CFG_MAX_POWER_TIME: r_max_power_time <= i_cfg_data;
                svprc_pkg::CFG_RELIEF_TIME:    r_relief_time    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_drive   = r_drive;
        n_elapsed = r_elapsed;
        n_relief  = r_relief;
        n_mode    = r_mode;
        n_error   = r_error;
        if (r_in.command != svprc_pkg::CMD_TICK) begin
            case (r_in.action)
                svprc_pkg::ACT_NONE: begin
                    n_mode = svprc_pkg::MODE_NONE;
                end
                svprc_pkg::ACT_CLOSE: begin
                    n_drive   = close_lvl;
                    n_elapsed = '0;
                    n_relief  = 1'b0;
                    n_mode    = svprc_pkg::MODE_CLOSE;
                end
                svprc_pkg::ACT_OPEN: begin
                    n_drive   = open_lvl;
                    n_elapsed = '0;
                    n_relief  = 1'b0;
                    n_mode    = svprc_pkg::MODE_OPEN;
                end
                svprc_pkg::ACT_PULSE: begin
                    // relief flag deliberately left alone
                    n_drive   = open_lvl;
                    n_elapsed = '0;
                    n_mode    = svprc_pkg::MODE_PULSE;
                end
                default: begin
                    n_error = 1'b1;
                end
            endcase
        end else begin
            if (r_elapsed != TIME_MAX) begin
                n_elapsed = r_elapsed + TIME_ONE;
            end
            // pulse check first, relief check sees its outcome
            if (r_mode == svprc_pkg::MODE_PULSE && n_elapsed >= r_pulse_time) begin
                n_drive   = close_lvl;
                n_elapsed = '0;
                n_relief  = 1'b0;
                n_mode    = svprc_pkg::MODE_NONE;
            end
            if (r_special_valve) begin
                if (n_drive) begin
                    if (n_elapsed >= r_max_power_time) begin
                        n_drive   = 1'b0;
                        n_elapsed = '0;
                        n_relief  = 1'b1;
                    end
                end else if (n_relief && n_elapsed >= r_relief_time) begin
                    n_drive   = 1'b1;
                    n_elapsed = '0;
                    n_relief  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_drive     <= 1'b0;
            r_elapsed   <= '0;
            r_relief    <= 1'b0;
            r_mode      <= svprc_pkg::MODE_NONE;
            r_error     <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (advance && r_in_valid) begin
                r_drive   <= n_drive;
                r_elapsed <= n_elapsed;
                r_relief  <= n_relief;
                r_mode    <= n_mode;
                r_error   <= n_error;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_data;
        end
        if (advance && r_in_valid) begin
            r_out.drive_level <= n_drive;
            r_out.valve_open  <= (n_drive == open_lvl);
            r_out.mode        <= n_mode;
            r_out.relieving   <= n_relief;
            r_out.error_flag  <= n_error;
        end
    end

endmodule

// ===== src/svprc_checker.sv =====
// Port-level checks for the solenoid valve controller, bound to the top.
// Depends on svprc_pkg and the assertion macro header.
`include "solenoid_valve_pulse_relief_controller_core_assert.svh"

module svprc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input svprc_pkg::t_out                 o_data,
    input logic                            i_cfg_we
);

    logic out_take;

    assign out_take = o_valid && i_ready;

    // stalled result beat holds
    `SVPRC_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_data))
    // error flag never clears once a result showed it
    `SVPRC_ASSERT(a_err_sticky, i_clk, i_rst_n, out_take && o_data.error_flag |=> !o_valid || o_data.error_flag)
    // input side only backs up when the result register is full and stalled
    `SVPRC_ASSERT(a_ready_backpressure, i_clk, i_rst_n, !o_ready |-> o_valid && !i_ready)
    // register writes only while nothing is in flight
    `SVPRC_ASSERT(a_cfg_idle, i_clk, i_rst_n, i_cfg_we |-> !i_valid && !o_valid)
    // reset empties the result register
    `SVPRC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind solenoid_valve_pulse_relief_controller_core svprc_checker u_svprc_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for solenoid_valve_pulse_relief_controller_core.
// Predicts every result beat from a local valve model; depends on svprc_pkg.
// Random driver/receiver idling, one long receiver hold, phased register setups.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TIME_W    = svprc_pkg::TIME_W;
    localparam int unsigned CFG_IDX_W = svprc_pkg::CFG_IDX_W;
    localparam logic CMD_ACT = ~svprc_pkg::CMD_TICK;
    localparam logic [TIME_W-1:0] ONE_MS = {{(TIME_W-1){1'b0}}, 1'b1};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    svprc_pkg::t_in       i_data = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    svprc_pkg::t_out      o_data;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [TIME_W-1:0]    i_cfg_data = '0;

    solenoid_valve_pulse_relief_controller_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // local copy of the valve registers
    logic              cfg_nopen   = 1'b0;
    logic              cfg_special = 1'b0;
    logic [TIME_W-1:0] cfg_pulse   = svprc_pkg::PULSE_TIME_RST;
    logic [TIME_W-1:0] cfg_maxpow  = svprc_pkg::MAX_POWER_TIME_RST;
    logic [TIME_W-1:0] cfg_relief  = svprc_pkg::RELIEF_TIME_RST;

    // local copy of the valve state
    logic              v_drive   = 1'b0;
    logic [TIME_W-1:0] v_elapsed = '0;
    logic              v_relief  = 1'b0;
    logic [1:0]        v_mode    = svprc_pkg::MODE_NONE;
    logic              v_err     = 1'b0;

    svprc_pkg::t_in  valve_cmds[$];
    svprc_pkg::t_out valve_states_due[$];

    int   n_errors = 0;
    bit   tx_idle_en = 1'b1;
    bit   rx_idle_en = 1'b1;
    bit   hold_req = 1'b0;
    bit   hold_done = 1'b0;
    int   tx_wait = 0;
    int   rx_wait = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #200_000;
        $display("testbench NOT OK");
        $finish;
    end

    // Valve state after one beat; updates the local state.
    function automatic svprc_pkg::t_out advance_valve(svprc_pkg::t_in beat);
        logic open_lvl;
        svprc_pkg::t_out r;
        open_lvl = ~cfg_nopen;
        if (beat.command == CMD_ACT) begin
            case (beat.action)
                svprc_pkg::ACT_NONE: v_mode = svprc_pkg::MODE_NONE;
                svprc_pkg::ACT_CLOSE: begin
                    v_drive   = ~open_lvl;
                    v_elapsed = '0;
                    v_relief  = 1'b0;
                    v_mode    = svprc_pkg::MODE_CLOSE;
                end
                svprc_pkg::ACT_OPEN: begin
                    v_drive   = open_lvl;
                    v_elapsed = '0;
                    v_relief  = 1'b0;
                    v_mode    = svprc_pkg::MODE_OPEN;
                end
                svprc_pkg::ACT_PULSE: begin
                    // relief flag deliberately left alone
                    v_drive   = open_lvl;
                    v_elapsed = '0;
                    v_mode    = svprc_pkg::MODE_PULSE;
                end
                default: v_err = 1'b1;
            endcase
        end else begin
            if (v_elapsed != '1)
                v_elapsed = v_elapsed + ONE_MS;
            if (v_mode == svprc_pkg::MODE_PULSE && v_elapsed >= cfg_pulse) begin
                v_drive   = ~open_lvl;
                v_elapsed = '0;
                v_relief  = 1'b0;
                v_mode    = svprc_pkg::MODE_NONE;
            end
            if (cfg_special) begin
                if (v_drive) begin
                    if (v_elapsed >= cfg_maxpow) begin
                        v_drive   = 1'b0;
                        v_elapsed = '0;
                        v_relief  = 1'b1;
                    end
                end else if (v_relief && v_elapsed >= cfg_relief) begin
                    v_drive   = 1'b1;
                    v_elapsed = '0;
                    v_relief  = 1'b0;
                end
            end
        end
        r.drive_level = v_drive;
        r.valve_open  = (v_drive == open_lvl);
        r.mode        = v_mode;
        r.relieving   = v_relief;
        r.error_flag  = v_err;
        return r;
    endfunction

    // Driver: offers queued commands, random gap after each accepted beat.
    always @(posedge i_clk) begin : driver
        int gap;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_wait <= 0;
        end else if (i_valid && o_ready) begin
            valve_states_due.push_back(advance_valve(i_data));
            gap = tx_idle_en ? $urandom_range(6, 0) : 0;
            if (gap == 0 && valve_cmds.size() > 0) begin
                i_data <= valve_cmds.pop_front();
            end else begin
                i_valid <= 1'b0;
                tx_wait <= gap;
            end
        end else if (!i_valid) begin
            if (tx_wait > 0) begin
                tx_wait <= tx_wait - 1;
            end else if (valve_cmds.size() > 0) begin
                i_valid <= 1'b1;
                i_data  <= valve_cmds.pop_front();
            end
        end
    end

    // Monitor: checks each result beat, random stall after each one.
    always @(posedge i_clk) begin : monitor
        svprc_pkg::t_out want;
        int   stall;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_wait <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (valve_states_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, o_data);
                    n_errors++;
                end else begin
                    want = valve_states_due.pop_front();
                    if (o_data.drive_level !== want.drive_level) begin
                        $display("%0t: drive_level expected %0d, got %0d",
                                 $time, want.drive_level, o_data.drive_level);
                        n_errors++;
                    end
                    if (o_data.valve_open !== want.valve_open) begin
                        $display("%0t: valve_open expected %0d, got %0d",
                                 $time, want.valve_open, o_data.valve_open);
                        n_errors++;
                    end
                    if (o_data.mode !== want.mode) begin
                        $display("%0t: mode expected %0d, got %0d",
                                 $time, want.mode, o_data.mode);
                        n_errors++;
                    end
                    if (o_data.relieving !== want.relieving) begin
                        $display("%0t: relieving expected %0d, got %0d",
                                 $time, want.relieving, o_data.relieving);
                        n_errors++;
                    end
                    if (o_data.error_flag !== want.error_flag) begin
                        $display("%0t: error_flag expected %0d, got %0d",
                                 $time, want.error_flag, o_data.error_flag);
                        n_errors++;
                    end
                end
            end
            if (hold_req && !hold_done) begin
                // long hold so the block backs up and drops o_ready
                i_ready   <= 1'b0;
                rx_wait   <= 60;
                hold_done <= 1'b1;
            end else if (o_valid && i_ready) begin
                stall = rx_idle_en ? $urandom_range(6, 0) : 0;
                if (stall != 0) begin
                    i_ready <= 1'b0;
                    rx_wait <= stall;
                end
            end else if (!i_ready) begin
                if (rx_wait > 1) begin
                    rx_wait <= rx_wait - 1;
                end else begin
                    i_ready <= 1'b1;
                    rx_wait <= 0;
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            svprc_pkg::CFG_NORMALLY_OPEN:  cfg_nopen   = val[0];
            svprc_pkg::CFG_SPECIAL_VALVE:  cfg_special = val[0];
            svprc_pkg::CFG_PULSE_TIME:     cfg_pulse   = val;
            svprc_pkg::CFG_MAX_POWER_TIME: cfg_maxpow  = val;
            svprc_pkg::CFG_RELIEF_TIME:    cfg_relief  = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(logic nopen, logic special, logic [TIME_W-1:0] pulse,
                                 logic [TIME_W-1:0] maxpow, logic [TIME_W-1:0] relief);
        write_reg(svprc_pkg::CFG_NORMALLY_OPEN, {15'd0, nopen});
        write_reg(svprc_pkg::CFG_SPECIAL_VALVE, {15'd0, special});
        write_reg(svprc_pkg::CFG_PULSE_TIME, pulse);
        write_reg(svprc_pkg::CFG_MAX_POWER_TIME, maxpow);
        write_reg(svprc_pkg::CFG_RELIEF_TIME, relief);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Block is idle once every command is taken and every result seen.
    task automatic drain();
        do
            @(negedge i_clk);
        while (valve_cmds.size() != 0 || i_valid || valve_states_due.size() != 0);
    endtask

    task automatic push_cmd(logic command, logic [2:0] action);
        svprc_pkg::t_in beat;
        beat.command = command;
        beat.action  = action;
        valve_cmds.push_back(beat);
    endtask

    function automatic logic [TIME_W-1:0] pick_ms();
        int r;
        r = $urandom_range(9, 0);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r == 2)
            return TIME_W'($urandom_range(65535, 0));
        return TIME_W'($urandom_range(10, 1));
    endfunction

    // Mostly an actuation followed by a run of ticks, sometimes a stray beat.
    task automatic queue_valve_traffic(int n, bit with_bad);
        int made;
        int r;
        int k;
        made = 0;
        while (made < n) begin
            r = $urandom_range(9, 0);
            if (r < 7) begin
                r = $urandom_range(5, 0);
                push_cmd(CMD_ACT, (r > 3) ? svprc_pkg::ACT_PULSE : 3'(r));
                made++;
                k = $urandom_range(12, 0);
                repeat (k) begin
                    push_cmd(svprc_pkg::CMD_TICK, 3'($urandom_range(7, 0)));
                    made++;
                end
            end else begin
                push_cmd(1'($urandom_range(1, 0)),
                         with_bad ? 3'($urandom_range(7, 0)) : 3'($urandom_range(3, 0)));
                made++;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: every actuation, ticks far below the 1000 ms times
        push_cmd(svprc_pkg::CMD_TICK, 3'd7);
        push_cmd(CMD_ACT, svprc_pkg::ACT_CLOSE);
        push_cmd(CMD_ACT, svprc_pkg::ACT_OPEN);
        push_cmd(svprc_pkg::CMD_TICK, 3'd4);
        push_cmd(CMD_ACT, svprc_pkg::ACT_NONE);
        push_cmd(CMD_ACT, svprc_pkg::ACT_PULSE);
        push_cmd(svprc_pkg::CMD_TICK, 3'd0);
        push_cmd(CMD_ACT, svprc_pkg::ACT_CLOSE);
        push_cmd(svprc_pkg::CMD_TICK, 3'd2);
        drain();

        // inverted polarity, special valve, zero power time: relief cycling,
        // pulse keeps relief, pulse expiry then immediate relief
        load_settings(1'b1, 1'b1, 16'd2, 16'd0, 16'd1);
        push_cmd(CMD_ACT, svprc_pkg::ACT_OPEN);
        push_cmd(svprc_pkg::CMD_TICK, 3'd1);
        push_cmd(CMD_ACT, svprc_pkg::ACT_CLOSE);
        push_cmd(svprc_pkg::CMD_TICK, 3'd3);
        push_cmd(svprc_pkg::CMD_TICK, 3'd5);
        push_cmd(svprc_pkg::CMD_TICK, 3'd6);
        push_cmd(CMD_ACT, svprc_pkg::ACT_PULSE);
        push_cmd(svprc_pkg::CMD_TICK, 3'd0);
        push_cmd(svprc_pkg::CMD_TICK, 3'd7);
        push_cmd(svprc_pkg::CMD_TICK, 3'd0);
        push_cmd(CMD_ACT, svprc_pkg::ACT_NONE);
        drain();

        // polarity flip leaves the pin alone; zero pulse time closes on first tick
        load_settings(1'b0, 1'b0, 16'd0, 16'hFFFF, 16'd0);
        push_cmd(svprc_pkg::CMD_TICK, 3'd0);
        push_cmd(CMD_ACT, svprc_pkg::ACT_PULSE);
        push_cmd(svprc_pkg::CMD_TICK, 3'd0);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            load_settings(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                          pick_ms(), pick_ms(), pick_ms());
            tx_idle_en = ($urandom_range(3, 0) != 0);
            rx_idle_en = ($urandom_range(3, 0) != 0);
            if (ph == 3) begin
                tx_idle_en = 1'b0;
                hold_req   = 1'b1;
            end
            // unknown codes latch the error for good, so only at the end
            queue_valve_traffic(40, ph >= 8);
            drain();
        end

        repeat (4) @(posedge i_clk);
        if (valve_states_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, valve_states_due.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
